>>> src/vdm_pkg.sv
// Shared types and constants for the virtqueue descriptor manager.
// No dependencies; imported by every module of the block.
package vdm_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam logic [1:0] FLAG_NEXT  = 2'b01;
  localparam logic [1:0] FLAG_WRITE = 2'b10;

  typedef enum logic [1:0] {
    OP_SUBMIT     = 2'd0,
    OP_COMPLETE   = 2'd1,
    OP_READ_DESC  = 2'd2,
    OP_READ_AVAIL = 2'd3
  } vdm_op_t;

  // One classified request as it sits in the queue between front and back.
  typedef struct packed {
    vdm_op_t     op;
    logic [63:0] out_address;
    logic [31:0] out_length;
    logic [63:0] in_address;
    logic [31:0] in_length;
    logic [15:0] queue_select;
    logic [5:0]  used_id;
    logic [5:0]  read_index;
    logic        need_second;
    logic        used_ok;
    logic        read_ok;
    logic        id_match;
  } vdm_item_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [31:0] len;
    logic [1:0]  flags;
  } vdm_desc_t;

  typedef struct packed {
    logic        status;
    logic [5:0]  head_index;
    logic        notify;
    logic [15:0] notify_queue;
    logic [15:0] avail_index_now;
    logic [6:0]  freed_count;
    logic        awaited_done;
    logic [63:0] entry_address;
    logic [31:0] entry_length;
    logic [1:0]  entry_flags;
    logic [5:0]  entry_link;
  } vdm_result_t;

endpackage

>>> src/vdm_front.sv
// Front end: accepts request beats, classifies them and holds them in a
// two-entry queue for the back end. Depends on vdm_pkg.
module vdm_front #(
  parameter int QUEUE_DEPTH = vdm_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        operation,
  input  logic [63:0]       out_address,
  input  logic [31:0]       out_length,
  input  logic [63:0]       in_address,
  input  logic [31:0]       in_length,
  input  logic [15:0]       queue_select,
  input  logic [5:0]        used_id,
  input  logic [5:0]        awaited_head,
  input  logic [5:0]        read_index,
  output logic              q_valid,
  output vdm_pkg::vdm_item_t q_item,
  input  logic              q_pop
);
  import vdm_pkg::*;

  vdm_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  vdm_item_t  item;
  logic       push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_comb begin
    item.op           = vdm_op_t'(operation);
    item.out_address  = out_address;
    item.out_length   = out_length;
    item.in_address   = in_address;
    item.in_length    = in_length;
    item.queue_select = queue_select;
    item.used_id      = used_id;
    item.read_index   = read_index;
    item.need_second  = (in_length != 32'd0);
    item.used_ok      = (32'(used_id) < QUEUE_DEPTH);
    item.read_ok      = (32'(read_index) < QUEUE_DEPTH);
    item.id_match     = (used_id == awaited_head);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop && q_valid) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop && q_valid);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("request queue count out of range");
  assert property (@(posedge clk) disable iff (rst)
                   (count == 2'd0 && !push) |=> (count == 2'd0))
    else $error("request queue filled without a push");
  assert property (@(posedge clk) disable iff (rst)
                   (count == 2'd2 && !(q_pop && q_valid)) |=> (count == 2'd2))
    else $error("full request queue lost an entry");

endmodule

>>> src/vdm_back.sv
// Back end: sequencer over the free map, descriptor memories and avail ring,
// with the result register. Depends on vdm_pkg.
module vdm_back #(
  parameter int QUEUE_DEPTH = vdm_pkg::DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  vdm_pkg::vdm_item_t   q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vdm_pkg::vdm_result_t out_res
);
  import vdm_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SUB0 = 7'b0000010,
    ST_SUB1 = 7'b0000100,
    ST_SUB2 = 7'b0001000,
    ST_WAIT = 7'b0010000,
    ST_WCHK = 7'b0100000,
    ST_RDD  = 7'b1000000
  } state_t;

  state_t      state, state_next;
  vdm_item_t   item, item_next;
  logic [QUEUE_DEPTH-1:0] free, free_next;
  logic [IW-1:0] d0, d0_next;
  logic [IW-1:0] rd_addr, rd_addr_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [15:0] avail_cnt, avail_cnt_next;
  logic [IW-1:0] slot, slot_next;

  vdm_desc_t   dmem [QUEUE_DEPTH];
  logic [IW-1:0] nmem [QUEUE_DEPTH];
  logic [IW-1:0] amem [QUEUE_DEPTH];
  vdm_desc_t   d_rdata;
  logic [IW-1:0] n_rdata;
  logic [IW-1:0] a_rdata;

  logic        dm_we, nm_we, am_we;
  logic [IW-1:0] dm_wa, nm_wa;
  vdm_desc_t   dm_wd;
  logic [IW-1:0] nm_wd;

  logic        low_found;
  logic [IW-1:0] low_idx;
  logic        blocked;
  logic        emit;
  vdm_result_t res;
  logic [CW-1:0] cnt_inc;

  // Lowest free descriptor.
  always_comb begin
    low_found = 1'b0;
    low_idx   = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (free[i]) begin
        low_found = 1'b1;
        low_idx   = IW'(i);
      end
    end
  end

  assign blocked = out_valid && !out_ready;
  assign cnt_inc = cnt + CW'(1);

  always_comb begin
    state_next     = state;
    item_next      = item;
    free_next      = free;
    d0_next        = d0;
    rd_addr_next   = rd_addr;
    cnt_next       = cnt;
    avail_cnt_next = avail_cnt;
    slot_next      = slot;
    q_pop          = 1'b0;
    emit           = 1'b0;
    dm_we          = 1'b0;
    dm_wa          = d0;
    dm_wd          = '0;
    nm_we          = 1'b0;
    nm_wa          = d0;
    nm_wd          = low_idx;
    am_we          = 1'b0;
    res            = '0;
    res.avail_index_now = avail_cnt;

    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          item_next = q_item;
          cnt_next  = '0;
          if (q_item.op == OP_COMPLETE) begin
            rd_addr_next = IW'(q_item.used_id);
          end else begin
            rd_addr_next = IW'(q_item.read_index);
          end
          if (q_item.op == OP_SUBMIT) state_next = ST_SUB0;
          else                        state_next = ST_WAIT;
        end
      end
      ST_SUB0: begin
        if (!blocked) begin
          if (!low_found) begin
            emit       = 1'b1;
            res.status = 1'b1;
            state_next = ST_IDLE;
          end else begin
            free_next[low_idx] = 1'b0;
            dm_we   = 1'b1;
            dm_wa   = low_idx;
            dm_wd   = '{addr: item.out_address, len: item.out_length, flags: 2'b00};
            d0_next = low_idx;
            if (item.need_second) begin
              state_next = ST_SUB1;
            end else begin
              am_we          = 1'b1;
              avail_cnt_next = avail_cnt + 16'd1;
              emit           = 1'b1;
              res.head_index = 6'(low_idx);
              res.notify     = 1'b1;
              res.notify_queue    = item.queue_select;
              res.avail_index_now = avail_cnt + 16'd1;
              state_next     = ST_IDLE;
            end
          end
        end
      end
      ST_SUB1: begin
        if (!low_found) begin
          // The first descriptor stays written but goes back to the free map.
          if (!blocked) begin
            free_next[d0] = 1'b1;
            emit          = 1'b1;
            res.status    = 1'b1;
            state_next    = ST_IDLE;
          end
        end else begin
          free_next[low_idx] = 1'b0;
          dm_we      = 1'b1;
          dm_wa      = low_idx;
          dm_wd      = '{addr: item.in_address, len: item.in_length, flags: FLAG_WRITE};
          nm_we      = 1'b1;
          state_next = ST_SUB2;
        end
      end
      ST_SUB2: begin
        if (!blocked) begin
          dm_we          = 1'b1;
          dm_wd          = '{addr: item.out_address, len: item.out_length, flags: FLAG_NEXT};
          am_we          = 1'b1;
          avail_cnt_next = avail_cnt + 16'd1;
          emit           = 1'b1;
          res.head_index = 6'(d0);
          res.notify     = 1'b1;
          res.notify_queue    = item.queue_select;
          res.avail_index_now = avail_cnt + 16'd1;
          state_next     = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (item.op == OP_COMPLETE) begin
          if (!item.used_ok) begin
            if (!blocked) begin
              emit             = 1'b1;
              res.awaited_done = item.id_match;
              state_next       = ST_IDLE;
            end
          end else begin
            state_next = ST_WCHK;
          end
        end else begin
          state_next = ST_RDD;
        end
      end
      ST_WCHK: begin
        if (!blocked) begin
          free_next[rd_addr] = 1'b1;
          cnt_next           = cnt_inc;
          if (!d_rdata.flags[0] || cnt_inc == CW'(QUEUE_DEPTH)) begin
            emit             = 1'b1;
            res.freed_count  = 7'(cnt_inc);
            res.awaited_done = item.id_match;
            state_next       = ST_IDLE;
          end else begin
            rd_addr_next = n_rdata;
            state_next   = ST_WAIT;
          end
        end
      end
      ST_RDD: begin
        if (!blocked) begin
          emit = 1'b1;
          if (item.read_ok) begin
            if (item.op == OP_READ_DESC) begin
              res.entry_address = d_rdata.addr;
              res.entry_length  = d_rdata.len;
              res.entry_flags   = d_rdata.flags;
              res.entry_link    = 6'(n_rdata);
            end else begin
              res.entry_link = 6'(a_rdata);
            end
          end
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // The ring slot follows the counter modulo the depth, also across its wrap.
    if (am_we) begin
      if (avail_cnt == 16'hFFFF || slot == IW'(QUEUE_DEPTH - 1)) slot_next = '0;
      else slot_next = slot + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (dm_we) dmem[dm_wa] <= dm_wd;
    if (nm_we) nmem[nm_wa] <= nm_wd;
    if (am_we) amem[slot] <= d0_next;
    d_rdata <= dmem[rd_addr];
    n_rdata <= nmem[rd_addr];
    a_rdata <= amem[rd_addr];
  end

  always_ff @(posedge clk) begin
    item    <= item_next;
    d0      <= d0_next;
    rd_addr <= rd_addr_next;
    cnt     <= cnt_next;
    if (emit) out_res <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      free      <= '1;
      avail_cnt <= 16'd0;
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      free      <= free_next;
      avail_cnt <= avail_cnt_next;
      slot      <= slot_next;
      if (emit)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) emit |-> !blocked)
    else $error("result register overwritten while stalled");
  assert property (@(posedge clk) disable iff (rst)
                   (state == ST_SUB1) |-> !free[d0])
    else $error("first descriptor not claimed during second claim");
  assert property (@(posedge clk) disable iff (rst)
                   $past(!rst) |-> (avail_cnt == $past(avail_cnt) ||
                                    avail_cnt == $past(avail_cnt) + 16'd1))
    else $error("avail index moved by more than one");
  assert property (@(posedge clk) disable iff (rst)
                   (am_we) |-> (state == ST_SUB0 || state == ST_SUB2))
    else $error("avail ring written outside a submit");

endmodule

>>> src/virtqueue_descriptor_manager_top.sv
// Top level of the virtqueue descriptor manager: front end, request queue
// and back end. Depends on vdm_pkg, vdm_front and vdm_back.
//
//   channel   handshake              payload
//   request   in_valid / in_ready    operation .. read_index
//   result    out_valid / out_ready  status .. entry_link
//
// Each beat leaves the queue, then a submit claims one or two descriptors,
// a completion walks its chain and a read fetches one entry; the walk is set
// by one registered read of the descriptor memory per step.
// Reset clears the free map (all free), the avail index and the queue.
// A stalled result holds the back end at its next result; the queue keeps taking requests until it holds two.
module virtqueue_descriptor_manager_top #(
  parameter int QUEUE_DEPTH = vdm_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [63:0] out_address,
  input  logic [31:0] out_length,
  input  logic [63:0] in_address,
  input  logic [31:0] in_length,
  input  logic [15:0] queue_select,
  input  logic [5:0]  used_id,
  input  logic [5:0]  awaited_head,
  input  logic [5:0]  read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [5:0]  head_index,
  output logic        notify,
  output logic [15:0] notify_queue,
  output logic [15:0] avail_index_now,
  output logic [6:0]  freed_count,
  output logic        awaited_done,
  output logic [63:0] entry_address,
  output logic [31:0] entry_length,
  output logic [1:0]  entry_flags,
  output logic [5:0]  entry_link
);
  import vdm_pkg::*;

  logic        q_valid;
  logic        q_pop;
  vdm_item_t   q_item;
  vdm_result_t res;

  vdm_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst, .in_valid, .in_ready, .operation, .out_address, .out_length,
    .in_address, .in_length, .queue_select, .used_id, .awaited_head,
    .read_index, .q_valid, .q_item, .q_pop
  );

  vdm_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk, .rst, .q_valid, .q_item, .q_pop, .out_valid, .out_ready,
    .out_res(res)
  );

  assign status          = res.status;
  assign head_index      = res.head_index;
  assign notify          = res.notify;
  assign notify_queue    = res.notify_queue;
  assign avail_index_now = res.avail_index_now;
  assign freed_count     = res.freed_count;
  assign awaited_done    = res.awaited_done;
  assign entry_address   = res.entry_address;
  assign entry_length    = res.entry_length;
  assign entry_flags     = res.entry_flags;
  assign entry_link      = res.entry_link;

endmodule
